### design/rss_sld_pkg.sv
// Shared constants for the RSS safe longitudinal distance block.
package rss_sld_pkg;

    // Default fixed-point fraction width.
    localparam int FRAC_BITS_DEF = 8;

    // Field widths.
    localparam int SPEED_W = 16;
    localparam int GAP_W   = 24;
    localparam int RT_W    = 12;
    localparam int ACC_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    // Quotient bits kept by the dividers; larger quotients flag overflow.
    localparam int QUO_W = 32;

    // Register indexes.
    localparam logic [CIDX_W-1:0] CFG_REACTION_TIME = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ACCEL_MAX     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BRAKE_MIN     = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_BRAKE_MAX     = 2'd3;

    // Reset values.
    localparam logic [RT_W-1:0]  RST_REACTION_TIME = 12'd256;
    localparam logic [ACC_W-1:0] RST_ACCEL_MAX     = 16'd512;
    localparam logic [ACC_W-1:0] RST_BRAKE_MIN     = 16'd1024;
    localparam logic [ACC_W-1:0] RST_BRAKE_MAX     = 16'd2048;

    localparam logic [GAP_W-1:0] GAP_MAX = {GAP_W{1'b1}};

endpackage

### design/rss_safe_longitudinal_distance_top.sv
// RSS minimum safe longitudinal distance: pipelined top level.
//
//  Channel   Signals                                      Direction
//  --------  -------------------------------------------  ---------
//  input     i_in_valid / o_in_ready, ego/other speed,     in
//            other_is_rear
//  output    o_out_valid / i_out_ready, safe_gap,          out
//            gap_saturated
//  config    i_cfg_we, i_cfg_idx, i_cfg_data               in
//
//  One transfer per cycle in each direction when not stalled.
//  Input transfer to result valid passes three front
//  stages (select, response speed, multiplies), 33 divider stages
//  (overflow check plus one quotient bit per stage) and three back stages.
//  Synchronous active-low reset clears valid bits and loads config defaults.
//  A stall at the output freezes the whole pipeline; o_in_ready drops with it.
module rss_safe_longitudinal_distance_top
    import rss_sld_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [SPEED_W-1:0] i_ego_speed,
    input  logic signed [SPEED_W-1:0] i_other_speed,
    input  logic                      i_other_is_rear,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [GAP_W-1:0]          o_safe_gap,
    output logic                      o_gap_saturated,
    // configuration writes
    input  logic                      i_cfg_we,
    input  logic [CIDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    // Width bookkeeping.
    localparam int V_W    = SPEED_W + 1;                     // speed magnitude
    localparam int AT_W   = ACC_W + RT_W;                    // accel * time
    localparam int ATS_W  = AT_W - FRAC_BITS;                // after rescale
    localparam int VR_W   = ((ATS_W > V_W) ? ATS_W : V_W) + 1; // response speed
    localparam int SUM_W  = VR_W + 1;                        // v + vr
    localparam int DURP_W = SUM_W + RT_W;                    // (v + vr) * t
    localparam int DUR_W  = DURP_W - (FRAC_BITS + 1);        // distance in response
    localparam int SQ_W   = 2 * VR_W;                        // vr squared
    localparam int STP_W  = 2 * SPEED_W;                     // stop speed squared
    localparam int DVS_W  = ACC_W + 1;                       // 2 * braking
    localparam int HI_W   = SQ_W - QUO_W;
    localparam int CMP_W  = (HI_W > DVS_W) ? HI_W : DVS_W;
    localparam int PW     = ((DUR_W > QUO_W) ? DUR_W : QUO_W) + 2;
    localparam int LANES  = 3;                               // resp A, resp B, stop

    typedef struct packed {
        logic [DUR_W-1:0] dur_a;
        logic [DUR_W-1:0] dur_b;
        logic             ovf_a;
        logic             ovf_b;
        logic             use_b;
        logic             use_c;
        logic             zero;
    } t_side;

    // Whole pipeline advances unless the result register is held.
    logic adv;
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // ---------------- configuration ----------------
    logic [RT_W-1:0]  r_reaction_time;
    logic [ACC_W-1:0] r_accel_max;
    logic [ACC_W-1:0] r_brake_min;
    logic [ACC_W-1:0] r_brake_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reaction_time <= RST_REACTION_TIME;
            r_accel_max     <= RST_ACCEL_MAX;
            r_brake_min     <= RST_BRAKE_MIN;
            r_brake_max     <= RST_BRAKE_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REACTION_TIME: r_reaction_time <= i_cfg_data[RT_W-1:0];
                CFG_ACCEL_MAX:     r_accel_max     <= i_cfg_data;
                CFG_BRAKE_MIN:     r_brake_min     <= i_cfg_data;
                CFG_BRAKE_MAX:     r_brake_max     <= i_cfg_data;
            endcase
        end
    end

    // Values derived from configuration, refreshed every cycle.
    // Config must only change while the pipeline is empty; the block does not enforce this.
    logic [ATS_W-1:0] r_at;
    logic [DVS_W-1:0] r_dvs_min;
    logic [DVS_W-1:0] r_dvs_max;
    logic [AT_W-1:0]  n_at_full;

    assign n_at_full = AT_W'(r_accel_max) * AT_W'(r_reaction_time);

    always_ff @(posedge i_clk) begin
        r_at      <= ATS_W'(n_at_full >> FRAC_BITS);
        // zero braking is treated as one
        r_dvs_min <= {((r_brake_min == '0) ? ACC_W'(1) : r_brake_min), 1'b0};
        r_dvs_max <= {((r_brake_max == '0) ? ACC_W'(1) : r_brake_max), 1'b0};
    end

    // ---------------- stage 1: case selection ----------------
    logic             ego_neg;
    logic             oth_neg;
    logic [V_W-1:0]   oth_mag;
    logic [V_W-1:0]   ego_ext;
    logic [V_W-1:0]   oth_ext;

    logic             r1_vld;
    logic [V_W-1:0]   r1_va;
    logic [V_W-1:0]   r1_vb;
    logic [SPEED_W-1:0] r1_vc;
    logic             r1_use_b;
    logic             r1_use_c;
    logic             r1_zero;

    always_comb begin
        ego_neg = i_ego_speed[SPEED_W-1];
        oth_neg = i_other_speed[SPEED_W-1];
        ego_ext = V_W'($unsigned(i_ego_speed));
        oth_ext = V_W'($unsigned(i_other_speed));
        oth_mag = oth_neg ? (V_W'(0) - {1'b1, i_other_speed}) : oth_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // A: ego (front) or other (rear); B: reversing car ahead; C: braking car
            r1_va    <= i_other_is_rear ? oth_ext : ego_ext;
            r1_vb    <= (!i_other_is_rear && oth_neg) ? oth_mag : '0;
            r1_vc    <= i_other_is_rear ? i_ego_speed : i_other_speed;
            r1_use_b <= !i_other_is_rear && oth_neg;
            r1_use_c <= i_other_is_rear || !oth_neg;
            r1_zero  <= ego_neg || (i_other_is_rear && oth_neg);
        end
    end

    // ---------------- stage 2: speed after response ----------------
    logic               r2_vld;
    logic [V_W-1:0]     r2_va;
    logic [V_W-1:0]     r2_vb;
    logic [VR_W-1:0]    r2_vra;
    logic [VR_W-1:0]    r2_vrb;
    logic [SPEED_W-1:0] r2_vc;
    logic               r2_use_b;
    logic               r2_use_c;
    logic               r2_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_va    <= r1_va;
            r2_vb    <= r1_vb;
            r2_vra   <= VR_W'(r1_va) + VR_W'(r_at);
            r2_vrb   <= VR_W'(r1_vb) + VR_W'(r_at);
            r2_vc    <= r1_vc;
            r2_use_b <= r1_use_b;
            r2_use_c <= r1_use_c;
            r2_zero  <= r1_zero;
        end
    end

    // ---------------- stage 3: products ----------------
    logic [SUM_W-1:0]  n_sum_a;
    logic [SUM_W-1:0]  n_sum_b;
    logic [DURP_W-1:0] n_durp_a;
    logic [DURP_W-1:0] n_durp_b;

    logic              r3_vld;
    logic [DUR_W-1:0]  r3_dur_a;
    logic [DUR_W-1:0]  r3_dur_b;
    logic [SQ_W-1:0]   r3_sq_a;
    logic [SQ_W-1:0]   r3_sq_b;
    logic [STP_W-1:0]  r3_sq_c;
    logic              r3_use_b;
    logic              r3_use_c;
    logic              r3_zero;

    always_comb begin
        n_sum_a  = SUM_W'(r2_va) + SUM_W'(r2_vra);
        n_sum_b  = SUM_W'(r2_vb) + SUM_W'(r2_vrb);
        n_durp_a = DURP_W'(n_sum_a) * DURP_W'(r_reaction_time);
        n_durp_b = DURP_W'(n_sum_b) * DURP_W'(r_reaction_time);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (adv) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_dur_a <= DUR_W'(n_durp_a >> (FRAC_BITS + 1));
            r3_dur_b <= DUR_W'(n_durp_b >> (FRAC_BITS + 1));
            r3_sq_a  <= SQ_W'(r2_vra) * SQ_W'(r2_vra);
            r3_sq_b  <= SQ_W'(r2_vrb) * SQ_W'(r2_vrb);
            r3_sq_c  <= STP_W'(r2_vc) * STP_W'(r2_vc);
            r3_use_b <= r2_use_b;
            r3_use_c <= r2_use_c;
            r3_zero  <= r2_zero;
        end
    end

    // ---------------- divider: restoring, one quotient bit per stage ----------------
    // Entry stage checks whether the quotient fits QUO_W bits; if not, the
    // gap is far beyond the output range and only the flag matters.
    logic [DVS_W-1:0] dvs_lane [LANES];
    logic [SQ_W-1:0]  div_in   [LANES];
    logic [CMP_W-1:0] hi_ext   [LANES];
    logic             ovf0     [LANES];

    logic [DVS_W-1:0] r_rem [LANES][QUO_W+1];
    logic [QUO_W-1:0] r_wrk [LANES][QUO_W+1];
    t_side            r_sb  [QUO_W+1];
    logic             r_dv  [QUO_W+1];

    logic [DVS_W:0]   n_trial [LANES][QUO_W];
    logic             n_ge    [LANES][QUO_W];
    logic [DVS_W-1:0] n_rem   [LANES][QUO_W];
    logic [QUO_W-1:0] n_wrk   [LANES][QUO_W];
    t_side            n_sb0;

    always_comb begin
        dvs_lane[0] = r_dvs_min;
        dvs_lane[1] = r_dvs_min;
        dvs_lane[2] = r_dvs_max;
        div_in[0]   = r3_sq_a;
        div_in[1]   = r3_sq_b;
        div_in[2]   = SQ_W'(r3_sq_c);
        for (int ln = 0; ln < LANES; ln++) begin
            hi_ext[ln] = CMP_W'(div_in[ln][SQ_W-1:QUO_W]);
            ovf0[ln]   = hi_ext[ln] >= CMP_W'(dvs_lane[ln]);
        end
        n_sb0.dur_a = r3_dur_a;
        n_sb0.dur_b = r3_dur_b;
        n_sb0.ovf_a = ovf0[0];
        n_sb0.ovf_b = ovf0[1];
        n_sb0.use_b = r3_use_b;
        n_sb0.use_c = r3_use_c;
        n_sb0.zero  = r3_zero;
    end

    always_comb begin
        for (int ln = 0; ln < LANES; ln++) begin
            for (int k = 0; k < QUO_W; k++) begin
                n_trial[ln][k] = {r_rem[ln][k], r_wrk[ln][k][QUO_W-1]};
                n_ge[ln][k]    = n_trial[ln][k] >= {1'b0, dvs_lane[ln]};
                n_rem[ln][k]   = n_ge[ln][k]
                               ? DVS_W'(n_trial[ln][k] - {1'b0, dvs_lane[ln]})
                               : DVS_W'(n_trial[ln][k]);
                n_wrk[ln][k]   = {r_wrk[ln][k][QUO_W-2:0], n_ge[ln][k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QUO_W; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_dv[0] <= r3_vld;
            for (int k = 0; k < QUO_W; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb[0] <= n_sb0;
            for (int k = 0; k < QUO_W; k++) begin
                r_sb[k+1] <= r_sb[k];
            end
            for (int ln = 0; ln < LANES; ln++) begin
                r_rem[ln][0] <= hi_ext[ln][DVS_W-1:0];
                r_wrk[ln][0] <= div_in[ln][QUO_W-1:0];
                for (int k = 0; k < QUO_W; k++) begin
                    r_rem[ln][k+1] <= n_rem[ln][k];
                    r_wrk[ln][k+1] <= n_wrk[ln][k];
                end
            end
        end
    end

    // ---------------- back stage 1: partial sums ----------------
    t_side            sb_end;
    logic             r4_vld;
    logic [PW-1:0]    r4_pa;
    logic [PW-1:0]    r4_pb;
    logic [QUO_W-1:0] r4_minus;
    logic             r4_big;
    logic             r4_zero;

    assign sb_end = r_sb[QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (adv) begin
            r4_vld <= r_dv[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_pa    <= PW'(sb_end.dur_a) + PW'(r_wrk[0][QUO_W]);
            r4_pb    <= sb_end.use_b ? (PW'(sb_end.dur_b) + PW'(r_wrk[1][QUO_W])) : '0;
            r4_minus <= sb_end.use_c ? r_wrk[2][QUO_W] : '0;
            r4_big   <= sb_end.ovf_a || (sb_end.use_b && sb_end.ovf_b);
            r4_zero  <= sb_end.zero;
        end
    end

    // ---------------- back stage 2: total ----------------
    logic             r5_vld;
    logic [PW-1:0]    r5_plus;
    logic [QUO_W-1:0] r5_minus;
    logic             r5_big;
    logic             r5_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (adv) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_plus  <= r4_pa + r4_pb;
            r5_minus <= r4_minus;
            r5_big   <= r4_big;
            r5_zero  <= r4_zero;
        end
    end

    // ---------------- back stage 3: clamp, saturate, result register ----------------
    logic [PW-1:0]    n_diff;
    logic [GAP_W-1:0] n_gap;
    logic             n_sat;
    logic             r_out_valid;
    logic [GAP_W-1:0] r_out_gap;
    logic             r_out_sat;

    always_comb begin
        n_diff = (r5_plus > PW'(r5_minus)) ? (r5_plus - PW'(r5_minus)) : '0;
        if (r5_zero) begin
            n_gap = '0;
            n_sat = 1'b0;
        end else if (r5_big || (n_diff > PW'(GAP_MAX))) begin
            n_gap = GAP_MAX;
            n_sat = 1'b1;
        end else begin
            n_gap = n_diff[GAP_W-1:0];
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_gap <= n_gap;
            r_out_sat <= n_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_safe_gap      = r_out_gap;
    assign o_gap_saturated = r_out_sat;

endmodule
